// ----- rtl/command_frame_encoder_crc16_defines.svh -----
`ifndef COMMAND_FRAME_ENCODER_CRC16_DEFINES_SVH
`define COMMAND_FRAME_ENCODER_CRC16_DEFINES_SVH

// same-cycle implication, held off during reset
`define CFE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("frame encoder check failed");

// next-cycle implication, held off during reset
`define CFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("frame encoder check failed");

`endif

// ----- rtl/cfecrc_pkg.sv -----
package cfecrc_pkg;

	typedef struct packed {
		logic [2:0]  mode;
		logic [7:0]  device_address;
		logic [15:0] register_address;
		logic [3:0]  byte_count;
		logic [63:0] data_bytes;
	} req_word_t;

	typedef struct packed {
		logic [7:0] frame_byte;
		logic       last_byte;
	} frame_word_t;

	typedef enum logic [1:0] {
		BK_DATA   = 2'd0,
		BK_CRC_LO = 2'd1,
		BK_CRC_HI = 2'd2
	} byte_kind_t;

	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REF   = 16'hA001;
	localparam logic [7:0]  HDR_BASE       = 8'h80;
	localparam logic [2:0]  DEV_MODE_LIMIT = 3'd2;

	// CRC-16/MODBUS, one byte, LSB first
	function automatic logic [15:0] crc_update(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REF;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// ----- rtl/command_frame_encoder_crc16.sv -----
// channel | dir | handshake                 | word
// req     | in  | req_valid / req_ready     | one command request
// frame   | out | frame_valid / frame_ready | one frame byte, last_byte on CRC high
//
// Frames are 6 to 4+MAX_DATA_BYTES+2 bytes; the byte sequencer issues one byte per cycle
// while stage s1 can take it. The next request is taken in the same cycle that its
// predecessor's final byte leaves the sequencer.
// Stages: s1 byte select, s2 CRC update / CRC insert, s3 output register.
// Async reset clears the sequencer's busy flag and step and all stage valid bits; no clearing pass.
// A stall on frame_ready holds every full stage in place; empty stages still fill.
`include "command_frame_encoder_crc16_defines.svh"

module command_frame_encoder_crc16 #(
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_ready,
	input  cfecrc_pkg::req_word_t    req,
	output logic                     frame_valid,
	input  logic                     frame_ready,
	output cfecrc_pkg::frame_word_t  frame
);
	import cfecrc_pkg::*;

	localparam int CNT_W  = $clog2(MAX_DATA_BYTES + 1);
	localparam int STEP_W = $clog2(MAX_DATA_BYTES + 6);
	localparam int DIDX_W = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

	localparam logic [STEP_W-1:0] STEP_HDR    = STEP_W'(0);
	localparam logic [STEP_W-1:0] STEP_DEV    = STEP_W'(1);
	localparam logic [STEP_W-1:0] STEP_REG_HI = STEP_W'(2);
	localparam logic [STEP_W-1:0] STEP_REG_LO = STEP_W'(3);

	typedef struct packed {
		logic [7:0]  frame_byte;
		byte_kind_t  kind;
		logic        first;
	} s1_word_t;

	// sequencer
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              dev_q;
	logic [7:0]        hdr_q;
	logic [7:0]        dev_byte_q;
	logic [15:0]       reg_q;
	logic [7:0]        data_q [MAX_DATA_BYTES];

	// pipeline
	logic        v_s1, v_s2, v_s3;
	s1_word_t    p_s1;
	logic [15:0] crc_q;
	frame_word_t p_s2, p_s3;

	logic              rdy_s1, rdy_s2, rdy_s3;
	logic              mv12;
	logic              emit, last_step, acc;
	logic [CNT_W-1:0]  cnt_eff;
	logic [STEP_W-1:0] step_cnt, step_nxt;
	logic [DIDX_W-1:0] didx;
	s1_word_t          sel;

	assign rdy_s3 = !v_s3 || frame_ready;
	assign rdy_s2 = !v_s2 || rdy_s3;
	assign rdy_s1 = !v_s1 || rdy_s2;
	assign mv12   = v_s1 && rdy_s2;

	assign step_cnt  = STEP_W'(cnt_q);
	assign emit      = busy_q && rdy_s1;
	assign last_step = step_q == step_cnt + STEP_W'(5);
	assign req_ready = !busy_q || (emit && last_step);
	assign acc       = req_valid && req_ready;

	always_comb begin
		if (req.byte_count == 4'd0) begin
			cnt_eff = CNT_W'(1);
		end else if (req.byte_count > 4'(MAX_DATA_BYTES)) begin
			cnt_eff = CNT_W'(MAX_DATA_BYTES);
		end else begin
			cnt_eff = CNT_W'(req.byte_count);
		end
	end

	assign step_nxt = (step_q == STEP_HDR && !dev_q) ? STEP_REG_HI : step_q + STEP_W'(1);
	assign didx     = DIDX_W'(step_cnt + STEP_W'(3) - step_q);

	always_comb begin
		sel.frame_byte = 8'h00;
		sel.kind       = BK_DATA;
		sel.first      = 1'b0;
		if (step_q == STEP_HDR) begin
			sel.frame_byte = hdr_q;
			sel.first      = 1'b1;
		end else if (step_q == STEP_DEV) begin
			sel.frame_byte = dev_byte_q;
		end else if (step_q == STEP_REG_HI) begin
			sel.frame_byte = reg_q[15:8];
		end else if (step_q == STEP_REG_LO) begin
			sel.frame_byte = reg_q[7:0];
		end else if (step_q <= step_cnt + STEP_W'(3)) begin
			sel.frame_byte = data_q[didx];
		end else if (step_q == step_cnt + STEP_W'(4)) begin
			sel.kind = BK_CRC_LO;
		end else begin
			sel.kind = BK_CRC_HI;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= STEP_HDR;
		end else if (acc) begin
			busy_q <= 1'b1;
			step_q <= STEP_HDR;
		end else if (emit && last_step) begin
			busy_q <= 1'b0;
		end else if (emit) begin
			step_q <= step_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cnt_q      <= cnt_eff;
			dev_q      <= req.mode < DEV_MODE_LIMIT;
			hdr_q      <= HDR_BASE | {1'b0, req.mode, 4'h0} | {5'h00, 3'(cnt_eff - CNT_W'(1))};
			dev_byte_q <= req.device_address;
			reg_q      <= req.register_address;
			for (int k = 0; k < MAX_DATA_BYTES; k++) begin
				data_q[k] <= req.data_bytes[k*8 +: 8];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= emit;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			p_s1 <= sel;
		end
		if (mv12) begin
			p_s2.last_byte <= p_s1.kind == BK_CRC_HI;
			case (p_s1.kind)
				BK_CRC_LO: p_s2.frame_byte <= crc_q[7:0];
				BK_CRC_HI: p_s2.frame_byte <= crc_q[15:8];
				default: begin
					p_s2.frame_byte <= p_s1.frame_byte;
					crc_q <= crc_update(p_s1.first ? CRC_INIT : crc_q, p_s1.frame_byte);
				end
			endcase
		end
		if (v_s2 && rdy_s3) begin
			p_s3 <= p_s2;
		end
	end

	assign frame_valid = v_s3;
	assign frame       = p_s3;

	`CFE_ASSERT_NEXT(a_acc_restarts, clk, arst_n, acc, busy_q && step_q == STEP_HDR)
	`CFE_ASSERT_IMPLIES(a_step_bound, clk, arst_n, busy_q, step_q <= step_cnt + STEP_W'(5))
	`CFE_ASSERT_IMPLIES(a_dev_mode, clk, arst_n, busy_q && step_q == STEP_DEV, dev_q && hdr_q[6:5] == 2'b00)
	`CFE_ASSERT_IMPLIES(a_hdr_mark, clk, arst_n, v_s1 && p_s1.first, p_s1.frame_byte[7] && p_s1.kind == BK_DATA)

endmodule
